/* design/ldd_pkg.sv */
// Package for the light dip detector: shared widths, register indexes and the
// state record passed between the top level and the update logic.
// No dependencies.
package ldd_pkg;

   localparam int SAMPLE_W = 12;
   localparam int FRAC_W   = 16;
   localparam int AVG_W    = SAMPLE_W + FRAC_W;
   localparam int WEIGHT_W = 16;
   localparam int THR_W    = 12;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RESET = 16'd66;
   localparam logic [THR_W-1:0]    DIP_THR_RESET    = 12'd228;
   localparam logic [THR_W-1:0]    REARM_THR_RESET  = 12'd68;

   localparam logic [CSR_IDX_W-1:0] CSR_EMA_WEIGHT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIP_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REARM_THRESHOLD = 2'd2;

   typedef struct packed {
      logic [AVG_W-1:0]   avg;
      logic               armed;
      logic [COUNT_W-1:0] count;
   } ldd_state_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] ema_weight;
      logic [THR_W-1:0]    dip_threshold;
      logic [THR_W-1:0]    rearm_threshold;
   } ldd_cfg_type;

endpackage

/* design/ldd_update.sv */
// Next-state logic of the light dip detector: moving average update with
// rounding, then dip detection with hysteresis. Depends on ldd_pkg.
module ldd_update (
   input  ldd_pkg::ldd_state_type       state_cur,
   input  ldd_pkg::ldd_cfg_type         cfg,
   input  logic [ldd_pkg::SAMPLE_W-1:0] sample,
   output ldd_pkg::ldd_state_type       state_nxt,
   output logic                         dip_seen
);
   import ldd_pkg::*;

   localparam int DIFF_W = AVG_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
   localparam int STEP_W = PROD_W - FRAC_W;
   localparam int SUM_W  = STEP_W + 1;

   logic [AVG_W-1:0]         s16;
   logic signed [DIFF_W-1:0] diff;
   logic signed [WEIGHT_W:0] weight_s;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [STEP_W-1:0] step;
   logic signed [SUM_W-1:0]  sum;
   logic [AVG_W-1:0]         avg_new;
   logic signed [DIFF_W-1:0] below;
   logic signed [DIFF_W-1:0] above;
   logic signed [DIFF_W-1:0] dip_lim;
   logic signed [DIFF_W-1:0] rearm_lim;

   assign s16      = {sample, {FRAC_W{1'b0}}};
   assign diff     = $signed({1'b0, s16}) - $signed({1'b0, state_cur.avg});
   assign weight_s = $signed({1'b0, cfg.ema_weight});
   assign prod     = diff * weight_s;
   // Adding half an LSB and then flooring rounds to nearest, ties upward.
   assign prod_rnd = prod + $signed(PROD_W'(1) <<< (FRAC_W - 1));
   assign step     = prod_rnd[PROD_W-1:FRAC_W];
   assign sum      = $signed({{(SUM_W-AVG_W){1'b0}}, state_cur.avg})
                     + $signed({step[STEP_W-1], step});

   always_comb begin
      if (state_cur.avg == '0) begin
         avg_new = s16;
      end else if (sum < 0) begin
         avg_new = '0;
      end else if (sum > $signed({{(SUM_W-AVG_W){1'b0}}, AVG_MAX})) begin
         avg_new = AVG_MAX;
      end else begin
         avg_new = sum[AVG_W-1:0];
      end
   end

   assign below     = $signed({1'b0, avg_new}) - $signed({1'b0, s16});
   assign above     = -below;
   assign dip_lim   = $signed({1'b0, cfg.dip_threshold, {FRAC_W{1'b0}}});
   assign rearm_lim = $signed({1'b0, cfg.rearm_threshold, {FRAC_W{1'b0}}});

   always_comb begin
      state_nxt     = state_cur;
      state_nxt.avg = avg_new;
      dip_seen      = 1'b0;
      if (state_cur.armed) begin
         if (below > dip_lim) begin
            dip_seen        = 1'b1;
            state_nxt.armed = 1'b0;
            if (state_cur.count != COUNT_MAX) begin
               state_nxt.count = state_cur.count + 1'b1;
            end
         end
      end else if (above > rearm_lim) begin
         state_nxt.armed = 1'b1;
      end
   end

endmodule

/* design/light_dip_detector_unit.sv */
// Top level of the light dip detector: input register, configuration
// registers, detector state and result register. Depends on ldd_pkg and
// ldd_update.
//
//   channel  direction  transfer condition      payload
//   req      in         req_valid & !req_stall  req_sample
//   rsp      out        rsp_valid & !rsp_stall  rsp_average, rsp_dip_total,
//                                               rsp_dip_seen, rsp_armed
//   csr      in         csr_we                  csr_index, csr_wdata
//
// One sample per cycle is sustained while rsp is not stalled. A sample's result
// passes through the input register and then the result register before it is
// presented on rsp, and it transfers once rsp_stall is low.
// The average update and both threshold compares sit between those registers.
// Reset clears the detector state and loads the register defaults.
// While rsp is stalled, one more sample is held in the input register before
// req_stall rises.
module light_dip_detector_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ldd_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ldd_pkg::AVG_W-1:0]      rsp_average,
   output logic [ldd_pkg::COUNT_W-1:0]    rsp_dip_total,
   output logic                           rsp_dip_seen,
   output logic                           rsp_armed,
   input  logic                           csr_we,
   input  logic [ldd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ldd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ldd_pkg::*;

   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                out_valid_ff;
   logic [AVG_W-1:0]    out_avg_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_seen_ff;
   logic                out_armed_ff;
   ldd_cfg_type         cfg_ff;
   ldd_state_type       state_ff;
   ldd_state_type       state_in;
   logic                seen_in;
   logic                advance;
   logic                req_take;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ldd_update u_update (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .sample    (sample_ff),
      .state_nxt (state_in),
      .dip_seen  (seen_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ema_weight      <= EMA_WEIGHT_RESET;
         cfg_ff.dip_threshold   <= DIP_THR_RESET;
         cfg_ff.rearm_threshold <= REARM_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EMA_WEIGHT:      cfg_ff.ema_weight      <= csr_wdata[WEIGHT_W-1:0];
            CSR_DIP_THRESHOLD:   cfg_ff.dip_threshold   <= csr_wdata[THR_W-1:0];
            CSR_REARM_THRESHOLD: cfg_ff.rearm_threshold <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_avg_ff   <= state_in.avg;
         out_count_ff <= state_in.count;
         out_seen_ff  <= seen_in;
         out_armed_ff <= state_in.armed;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_average   = out_avg_ff;
   assign rsp_dip_total = out_count_ff;
   assign rsp_dip_seen  = out_seen_ff;
   assign rsp_armed     = out_armed_ff;

   // A counted dip always leaves the detector disarmed.
   a_dip_disarms: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_seen_ff) |-> !out_armed_ff)
      else $error("dip reported while detector still armed");

   // A sample waiting behind a stalled result is held in place.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> (in_valid_ff && $stable(sample_ff)))
      else $error("pending sample lost while result stalled");

   // The dip count never goes down.
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.count >= $past(state_ff.count)))
      else $error("dip count decreased");

   // The counter moves only when a dip is reported.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (advance && !seen_in) |=> $stable(state_ff.count))
      else $error("dip count changed without a dip");

endmodule
